// ===== rtl/core/ascm_pkg.sv =====
// ----------------------------------------------------------------------------
// ascm_pkg: allocation size-class mapper shared types and constants
// Holds the page and class-range constants, the residue-to-class table and
// the per-class tail table built at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package ascm_pkg;

	localparam int REQ_W        = 32;
	localparam int SIZE_W       = 33;
	localparam int SMALL_W      = 15;
	localparam int PAGE_BYTES   = 4096;
	localparam int PAGE_LOG2    = 12;
	localparam int ALIGN_LOG_W  = 4;
	localparam int ALIGN_LOG_MIN = 3;
	localparam int ALIGN_DIV_LOG = 3;
	localparam int CLASS_MOD    = 257;
	localparam int RES_W        = 9;
	localparam int CLASS_COUNT  = 72;
	localparam int CLASS_W      = 7;
	localparam int TAIL_W       = 15;
	localparam logic [7:0] NO_CLASS = 8'd255;

	typedef logic [7:0]        residue_tab_t [CLASS_MOD];
	typedef logic [TAIL_W-1:0] tail_tab_t    [CLASS_COUNT];

	typedef struct packed {
		logic [SIZE_W-1:0] alloc_size;
		logic              page_multiple;
	} sized_t;

	localparam residue_tab_t CLASS_BY_RESIDUE = '{
		8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd0,  8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd1,  8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd2,  8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd24,
		8'd3,  8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd4,  8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd5,  8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd6,  8'd255,8'd255,8'd255,8'd255,8'd36, 8'd32, 8'd25,
		8'd7,  8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd8,  8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd9,  8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd10, 8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd26,
		8'd11, 8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd12, 8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd13, 8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd14, 8'd46, 8'd44, 8'd42, 8'd40, 8'd37, 8'd33, 8'd27,
		8'd15, 8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd255,8'd71, 8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd16, 8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd255,8'd70, 8'd255,8'd255,8'd255,8'd255,8'd255,8'd28,
		8'd17, 8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd255,8'd69, 8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd18, 8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,8'd255,
		8'd255,8'd68, 8'd255,8'd255,8'd255,8'd38, 8'd34, 8'd29,
		8'd19, 8'd255,8'd255,8'd255,8'd255,8'd67, 8'd255,8'd255,
		8'd255,8'd66, 8'd255,8'd255,8'd255,8'd65, 8'd255,8'd255,
		8'd20, 8'd255,8'd255,8'd255,8'd255,8'd64, 8'd255,8'd255,
		8'd255,8'd63, 8'd255,8'd255,8'd255,8'd62, 8'd255,8'd30,
		8'd21, 8'd255,8'd255,8'd61, 8'd255,8'd60, 8'd255,8'd59,
		8'd255,8'd58, 8'd255,8'd57, 8'd255,8'd56, 8'd255,8'd55,
		8'd22, 8'd255,8'd54, 8'd53, 8'd52, 8'd51, 8'd50, 8'd49,
		8'd48, 8'd47, 8'd45, 8'd43, 8'd41, 8'd39, 8'd35, 8'd31,
		8'd23
	};

	// Walk every small class size (align 8: 1..16 units, wider aligns: 9..16 units)
	function automatic tail_tab_t build_tail_table();
		tail_tab_t  t;
		int         k;
		int         m;
		int         a;
		int         s;
		int         p;
		int         r;
		int         m_lo;
		logic [7:0] c;
		for (k = 0; k < CLASS_COUNT; k++) begin
			t[k] = '0;
		end
		for (k = ALIGN_LOG_MIN; k < SMALL_W - ALIGN_DIV_LOG + 1; k++) begin
			a    = 1 << k;
			m_lo = (k == ALIGN_LOG_MIN) ? 1 : 9;
			for (m = m_lo; m <= 16; m++) begin
				s = a * m;
				if ((s & (PAGE_BYTES - 1)) != 0) begin
					p = (s + PAGE_BYTES - 1) & ~(PAGE_BYTES - 1);
					r = p;
					while (r >= s) begin
						r = r - s;
					end
					c = CLASS_BY_RESIDUE[s % CLASS_MOD];
					if (c != NO_CLASS) begin
						t[c[CLASS_W-1:0]] = r[TAIL_W-1:0];
					end
				end
			end
		end
		return t;
	endfunction

	localparam tail_tab_t TAIL_BY_CLASS = build_tail_table();

endpackage

`default_nettype wire

// ===== rtl/core/ascm_round.sv =====
// ----------------------------------------------------------------------------
// ascm_round: request rounding stages
// Stage 1 fixes a zero request and finds the alignment from the top set bit;
// stage 2 rounds to that alignment or to whole pages and flags page multiples.
// ----------------------------------------------------------------------------
`default_nettype none

module ascm_round (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [ascm_pkg::REQ_W-1:0]   req,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output ascm_pkg::sized_t                  out_data
);

	localparam int SW  = ascm_pkg::SMALL_W;
	localparam int AW  = ascm_pkg::ALIGN_LOG_W;
	localparam int ZW  = ascm_pkg::SIZE_W;
	localparam int PL  = ascm_pkg::PAGE_LOG2;

	logic                        vld_s1;
	logic                        vld_s2;
	logic                        rdy_s1;
	logic                        rdy_s2;
	logic [ascm_pkg::REQ_W-1:0]  req_s1;
	logic                        small_s1;
	logic [AW-1:0]               alog_s1;
	ascm_pkg::sized_t            data_s2;

	logic [ascm_pkg::REQ_W-1:0]  req_fix;
	logic [AW-1:0]               top_idx;
	logic [AW-1:0]               alog_d;
	logic [SW:0]                 mask;
	logic [SW:0]                 small_sum;
	logic [ZW-1:0]               big_sum;
	logic [ZW-1:0]               size_d;

	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		req_fix = (req == '0) ? ascm_pkg::REQ_W'(1) : req;
		top_idx = '0;
		for (int i = 0; i < SW; i++) begin
			if (req_fix[i]) begin
				top_idx = AW'(i);
			end
		end
		if (top_idx < AW'(ascm_pkg::ALIGN_LOG_MIN + ascm_pkg::ALIGN_DIV_LOG)) begin
			alog_d = AW'(ascm_pkg::ALIGN_LOG_MIN);
		end else begin
			alog_d = top_idx - AW'(ascm_pkg::ALIGN_DIV_LOG);
		end
	end

	always_comb begin
		mask      = (SW+1)'(((SW+1)'(1) << alog_s1) - (SW+1)'(1));
		small_sum = {1'b0, req_s1[SW-1:0]} + mask;
		big_sum   = {1'b0, req_s1} + ZW'(ascm_pkg::PAGE_BYTES - 1);
		if (small_s1) begin
			size_d = ZW'(small_sum & ~mask);
		end else begin
			size_d = {big_sum[ZW-1:PL], {PL{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			req_s1   <= req_fix;
			small_s1 <= (req_fix[ascm_pkg::REQ_W-1:SW] == '0);
			alog_s1  <= alog_d;
		end
		if (rdy_s2 && vld_s1) begin
			data_s2.alloc_size    <= size_d;
			data_s2.page_multiple <= (size_d[PL-1:0] == '0);
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = data_s2;

endmodule

`default_nettype wire

// ===== rtl/core/ascm_class.sv =====
// ----------------------------------------------------------------------------
// ascm_class: class lookup stages
// Stage 3 reduces the rounded size modulo 257 and looks up its class;
// stage 4 fetches the tail bytes for that class and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ascm_class (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire ascm_pkg::sized_t               in_data,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [ascm_pkg::SIZE_W-1:0]         alloc_size,
	output logic                                page_multiple,
	output logic                                class_valid,
	output logic [ascm_pkg::CLASS_W-1:0]        class_index,
	output logic [ascm_pkg::TAIL_W-1:0]         tail_bytes
);

	localparam int RW = ascm_pkg::RES_W;
	localparam int CW = ascm_pkg::CLASS_W;

	logic                         vld_s3;
	logic                         vld_s4;
	logic                         rdy_s3;
	logic                         rdy_s4;
	ascm_pkg::sized_t             data_s3;
	logic [7:0]                   cls_s3;
	logic [ascm_pkg::SIZE_W-1:0]  size_s4;
	logic                         paged_s4;
	logic                         cv_s4;
	logic [CW-1:0]                idx_s4;
	logic [ascm_pkg::TAIL_W-1:0]  tail_s4;

	logic [RW:0]                  diff;
	logic [RW-1:0]                res;
	logic                         cv_d;

	assign rdy_s4   = !vld_s4 || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	// 256 is -1 modulo 257: fold the high byte back with a subtract
	always_comb begin
		diff = {2'b00, in_data.alloc_size[7:0]} - {3'b000, in_data.alloc_size[14:8]};
		if (diff[RW]) begin
			res = RW'(diff + (RW+1)'(ascm_pkg::CLASS_MOD));
		end else begin
			res = diff[RW-1:0];
		end
	end

	assign cv_d = !data_s3.page_multiple && (cls_s3 != ascm_pkg::NO_CLASS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				vld_s3 <= in_valid;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			data_s3 <= in_data;
			cls_s3  <= ascm_pkg::CLASS_BY_RESIDUE[res];
		end
		if (rdy_s4 && vld_s3) begin
			size_s4  <= data_s3.alloc_size;
			paged_s4 <= data_s3.page_multiple;
			cv_s4    <= cv_d;
			idx_s4   <= cv_d ? cls_s3[CW-1:0] : '0;
			tail_s4  <= cv_d ? ascm_pkg::TAIL_BY_CLASS[cls_s3[CW-1:0]] : '0;
		end
	end

	assign out_valid     = vld_s4;
	assign alloc_size    = size_s4;
	assign page_multiple = paged_s4;
	assign class_valid   = cv_s4;
	assign class_index   = idx_s4;
	assign tail_bytes    = tail_s4;

endmodule

`default_nettype wire

// ===== rtl/core/alloc_size_class_mapper.sv =====
// ----------------------------------------------------------------------------
// alloc_size_class_mapper: allocator size-class mapper
// Maps a requested byte count to its rounded class size, page flag,
// free-list class index and leftover tail bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: request_valid / request_ready with request_size.
//   Result channel: result_valid / result_ready with alloc_size, page_multiple,
//   class_valid, class_index and tail_bytes; one result per request, in order.
//   Pipeline: an accepted request passes four register stages (alignment,
//   rounding, modulo-257 class lookup, tail lookup) before its result is valid.
//   Throughput: one transaction per cycle with the receiver ready.
//   Reset: arst_n clears every stage valid bit; the pipeline comes out empty
//   and ready to accept a request on the first cycle.
//   Stall: with result_ready low, each stage holds its transaction; empty
//   stages still fill, and request_ready drops only once the stage ahead of
//   the input is full and held.
// ----------------------------------------------------------------------------
`default_nettype none

module alloc_size_class_mapper (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            request_valid,
	output logic                                 request_ready,
	input  wire logic [ascm_pkg::REQ_W-1:0]      request_size,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output logic [ascm_pkg::SIZE_W-1:0]          alloc_size,
	output logic                                 page_multiple,
	output logic                                 class_valid,
	output logic [ascm_pkg::CLASS_W-1:0]         class_index,
	output logic [ascm_pkg::TAIL_W-1:0]          tail_bytes
);

	logic              mid_valid;
	logic              mid_ready;
	ascm_pkg::sized_t  mid_data;

	ascm_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request_valid),
		.in_ready  (request_ready),
		.req       (request_size),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_data  (mid_data)
	);

	ascm_class u_class (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (mid_valid),
		.in_ready      (mid_ready),
		.in_data       (mid_data),
		.out_valid     (result_valid),
		.out_ready     (result_ready),
		.alloc_size    (alloc_size),
		.page_multiple (page_multiple),
		.class_valid   (class_valid),
		.class_index   (class_index),
		.tail_bytes    (tail_bytes)
	);

endmodule

`default_nettype wire

// ===== tb/tb_alloc_size_class_mapper.sv =====
// ----------------------------------------------------------------------------
// tb_alloc_size_class_mapper: size-class mapper testbench
// Drives byte-count requests through the valid/ready request channel in
// random bursts and drains results under a shifting stall pattern. Each
// accepted request is mapped to its expected class size, page flag, class
// index and tail bytes, and every result is checked in order against them.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [ascm_pkg::SIZE_W-1:0]  alloc_size;
	logic                         page_multiple;
	logic                         class_valid;
	logic [ascm_pkg::CLASS_W-1:0] class_index;
	logic [ascm_pkg::TAIL_W-1:0]  tail_bytes;
} class_result_t;

typedef struct packed {
	logic [ascm_pkg::REQ_W-1:0] request_size;
	class_result_t              result;
} class_entry_t;

class alloc_class_checker;
	localparam longint unsigned PAGE      = ascm_pkg::PAGE_BYTES;
	localparam longint unsigned SMALL_TOP = 32768;

	class_entry_t                pending_classes[$];
	logic [ascm_pkg::SIZE_W-1:0] class_sizes[$];
	int unsigned                 mismatches;

	// List every non-paged class size in ascending order; position is the index
	function new();
		logic [63:0] step;
		logic [63:0] s;
		int          k;
		int          m;
		mismatches = 0;
		for (k = 3; k <= 11; k++) begin
			step = 64'd1 << k;
			for (m = (k == 3) ? 1 : 9; m <= 16; m++) begin
				s = step * 64'(m);
				if (s % PAGE != 0)
					class_sizes.push_back(s[ascm_pkg::SIZE_W-1:0]);
			end
		end
	endfunction

	function class_result_t map_request(logic [ascm_pkg::REQ_W-1:0] req);
		class_result_t res;
		logic [63:0]   r;
		logic [63:0]   top;
		logic [63:0]   grain;
		logic [63:0]   s;
		logic [63:0]   span;
		res = '0;
		r = 64'(req);
		if (r == 0)
			r = 1;
		if (r < SMALL_TOP) begin
			top = 1;
			while ((top << 1) <= r)
				top = top << 1;
			grain = top / 8;
			if (grain < 8)
				grain = 8;
		end else begin
			grain = PAGE;
		end
		s = (r + grain - 1) & ~(grain - 1);
		res.alloc_size = s[ascm_pkg::SIZE_W-1:0];
		res.page_multiple = (s % PAGE) == 0;
		if (!res.page_multiple) begin
			span = ((s + PAGE - 1) / PAGE) * PAGE;
			res.tail_bytes = ascm_pkg::TAIL_W'(span % s);
			foreach (class_sizes[i]) begin
				if (class_sizes[i] == s[ascm_pkg::SIZE_W-1:0]) begin
					res.class_valid = 1'b1;
					res.class_index = ascm_pkg::CLASS_W'(i);
				end
			end
		end
		return res;
	endfunction

	function void note_request(logic [ascm_pkg::REQ_W-1:0] req);
		class_entry_t e;
		e.request_size = req;
		e.result = map_request(req);
		pending_classes.push_back(e);
	endfunction

	function void check_result(class_result_t got);
		class_entry_t e;
		if (pending_classes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: size %h paged %b valid %b index %0d tail %0d",
					got.alloc_size, got.page_multiple, got.class_valid, got.class_index,
					got.tail_bytes);
			return;
		end
		e = pending_classes.pop_front();
		if (got.alloc_size !== e.result.alloc_size ||
			got.page_multiple !== e.result.page_multiple ||
			got.class_valid !== e.result.class_valid ||
			got.class_index !== e.result.class_index ||
			got.tail_bytes !== e.result.tail_bytes) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch for request %h:", e.request_size);
				$display("  expected size %h paged %b valid %b index %0d tail %0d",
					e.result.alloc_size, e.result.page_multiple, e.result.class_valid,
					e.result.class_index, e.result.tail_bytes);
				$display("  actual   size %h paged %b valid %b index %0d tail %0d",
					got.alloc_size, got.page_multiple, got.class_valid, got.class_index,
					got.tail_bytes);
			end
		end
	endfunction

	function int pending_count();
		return pending_classes.size();
	endfunction
endclass

module tb_alloc_size_class_mapper;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 750;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam logic [31:0] CORNER_REQUESTS [25] = '{
		32'd0, 32'd1, 32'd7, 32'd8, 32'd9, 32'd63, 32'd64, 32'd127, 32'd128, 32'd129,
		32'd255, 32'd1025, 32'd4095, 32'd4096, 32'd4097, 32'd30000, 32'd32767,
		32'd32768, 32'd32769, 32'd36865, 32'h7FFF_FFFF, 32'h8000_0001,
		32'hFFFF_F000, 32'hFFFF_F001, 32'hFFFF_FFFF
	};

	logic                               clk;
	logic                               arst_n = 1'b0;
	logic                               request_valid = 1'b0;
	logic                               request_ready;
	logic [ascm_pkg::REQ_W-1:0]         request_size = '0;
	logic                               result_valid;
	logic                               result_ready = 1'b0;
	logic [ascm_pkg::SIZE_W-1:0]        alloc_size;
	logic                               page_multiple;
	logic                               class_valid;
	logic [ascm_pkg::CLASS_W-1:0]       class_index;
	logic [ascm_pkg::TAIL_W-1:0]        tail_bytes;
	logic [15:0]                        stall_tick = '0;

	alloc_class_checker board = new();

	alloc_size_class_mapper DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_ready (request_ready),
		.request_size  (request_size),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.alloc_size    (alloc_size),
		.page_multiple (page_multiple),
		.class_valid   (class_valid),
		.class_index   (class_index),
		.tail_bytes    (tail_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	// Check each result transaction and advance the stall pattern
	always @(posedge clk) begin
		class_result_t seen;
		if (arst_n && result_valid && result_ready) begin
			seen.alloc_size = alloc_size;
			seen.page_multiple = page_multiple;
			seen.class_valid = class_valid;
			seen.class_index = class_index;
			seen.tail_bytes = tail_bytes;
			board.check_result(seen);
		end
		stall_tick <= stall_tick + 1'b1;
		case (stall_tick[8:7])
			2'd0: result_ready <= 1'b1;
			2'd1: result_ready <= stall_tick[1:0] != 2'd3;
			2'd2: result_ready <= $urandom_range(0, 2) != 0;
			default: result_ready <= (stall_tick % 9) < 2;
		endcase
	end

	task automatic push_request(input logic [ascm_pkg::REQ_W-1:0] req);
		request_valid <= 1'b1;
		request_size <= req;
		do
			@(posedge clk);
		while (!request_ready);
		board.note_request(req);
	endtask

	task automatic drain_results();
		request_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_count() != 0)
			@(posedge clk);
	endtask

	function automatic logic [ascm_pkg::REQ_W-1:0] pick_request();
		logic [31:0] v;
		int unsigned w;
		int unsigned k;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				w = $urandom_range(0, 15);
				v = $urandom & ((32'd1 << w) - 1);
			end
			4, 5: begin
				k = $urandom_range(3, 11);
				v = (32'd1 << k) * $urandom_range((k == 3) ? 1 : 9, 16);
				v = v + $urandom_range(0, 2) - 1;
			end
			6: v = 32'd4096 * $urandom_range(1, 16) + $urandom_range(0, 2) - 1;
			7: v = $urandom;
			8: v = 32'hFFFF_FFFF - $urandom_range(0, 8192);
			default: begin
				w = $urandom_range(16, 32);
				v = (w == 32) ? $urandom : $urandom & ((32'd1 << w) - 1);
			end
		endcase
		return v;
	endfunction

	initial begin
		int  sent;
		int  burst;
		int  gap;
		int  i;
		bit  paused_early;
		bit  paused_late;
		sent = 0;
		paused_early = 1'b0;
		paused_late = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (CORNER_REQUESTS[j])
			push_request(CORNER_REQUESTS[j]);
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			for (i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				push_request(pick_request());
				sent++;
			end
			if (!paused_early && sent >= 250) begin
				paused_early = 1'b1;
				drain_results();
			end else if (!paused_late && sent >= 500) begin
				paused_late = 1'b1;
				drain_results();
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				request_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending_count() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
